// File: design/tofe_pkg.sv
// Shared types and constants for the TCP option field extractor.
`timescale 1ns / 1ps
package tofe_pkg;

    localparam logic [7:0] KIND_EOL   = 8'd0;
    localparam logic [7:0] KIND_NOP   = 8'd1;
    localparam logic [7:0] KIND_MSS   = 8'd2;
    localparam logic [7:0] KIND_WS    = 8'd3;
    localparam logic [7:0] KIND_SACKP = 8'd4;
    localparam logic [7:0] KIND_TS    = 8'd8;

    localparam logic [7:0] LEN_MSS   = 8'd4;
    localparam logic [7:0] LEN_WS    = 8'd3;
    localparam logic [7:0] LEN_SACKP = 8'd2;
    localparam logic [7:0] LEN_TS    = 8'd10;
    localparam logic [7:0] LEN_MIN   = 8'd2;

    localparam logic [1:0] PH_KIND = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam int unsigned WS_MAX_SHIFT = 62;
    localparam int unsigned FACTOR_W     = WS_MAX_SHIFT + 1;

    typedef struct packed {
        logic        mss_valid;
        logic [15:0] mss_value;
        logic        ws_valid;
        logic [7:0]  ws_shift;
        logic        sack;
        logic        ts_valid;
        logic [63:0] ts_word;
    } holds_t;

    typedef struct packed {
        logic                mss_valid;
        logic [15:0]         mss_value;
        logic                wscale_valid;
        logic [FACTOR_W-1:0] wscale_factor;
        logic                sack_permitted;
        logic                ts_valid;
        logic [31:0]         ts_value;
        logic [31:0]         ts_echo;
    } result_t;

    // Exact length required by a known kind; zero for kinds that are skipped.
    function automatic logic [7:0] opt_need_len(input logic [7:0] kind);
        logic [7:0] need;
        unique case (kind)
            KIND_MSS:   need = LEN_MSS;
            KIND_WS:    need = LEN_WS;
            KIND_SACKP: need = LEN_SACKP;
            KIND_TS:    need = LEN_TS;
            default:    need = 8'd0;
        endcase
        return need;
    endfunction

endpackage

// File: design/tcp_option_field_extractor_unit.sv
// Top level of the TCP option field extractor.
// channel | valid     | stall     | payload
// opt     | opt_valid | opt_stall | opt_byte, is_last, region_empty
// res     | res_valid | res_stall | mss_*, wscale_*, sack_permitted, ts_*
// One byte per cycle while opt_stall is low; when a region-ending request
// leaves the input register, its result is loaded into the result register.
// The walk state updates as a request leaves the input register.
// opt_stall rises only when a region-ending request waits on a full, stalled
// result register. Reset clears all walk state, holds and valid flags.
`timescale 1ns / 1ps
module tcp_option_field_extractor_unit #(
    parameter int unsigned MAX_OPT_BYTES = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        opt_valid,
    output logic        opt_stall,
    input  logic [7:0]  opt_byte,
    input  logic        is_last,
    input  logic        region_empty,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        mss_valid,
    output logic [15:0] mss_value,
    output logic        wscale_valid,
    output logic [62:0] wscale_factor,
    output logic        sack_permitted,
    output logic        ts_valid,
    output logic [31:0] ts_value,
    output logic [31:0] ts_echo
);

    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_empty_reg;
    logic              s1_ends;
    logic              s1_advance;
    logic              accept;

    logic              out_valid_reg;
    tofe_pkg::result_t result_reg;
    tofe_pkg::result_t result_next;
    tofe_pkg::holds_t  holds_after;

    assign s1_ends    = s1_last_reg | s1_empty_reg;
    assign s1_advance = s1_valid_reg && (!s1_ends || !out_valid_reg || !res_stall);
    assign opt_stall  = s1_valid_reg && !s1_advance;
    assign accept     = opt_valid && !opt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= opt_byte;
            s1_last_reg  <= is_last;
            s1_empty_reg <= region_empty;
        end
    end

    tofe_walk #(
        .MAX_OPT_BYTES (MAX_OPT_BYTES)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_advance),
        .opt_byte     (s1_byte_reg),
        .is_last      (s1_last_reg),
        .region_empty (s1_empty_reg),
        .holds_after  (holds_after)
    );

    tofe_emit u_emit (
        .holds  (holds_after),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_ends)
            out_valid_reg <= 1'b1;
        else if (!res_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_ends)
            result_reg <= result_next;
    end

    assign res_valid      = out_valid_reg;
    assign mss_valid      = result_reg.mss_valid;
    assign mss_value      = result_reg.mss_value;
    assign wscale_valid   = result_reg.wscale_valid;
    assign wscale_factor  = result_reg.wscale_factor;
    assign sack_permitted = result_reg.sack_permitted;
    assign ts_valid       = result_reg.ts_valid;
    assign ts_value       = result_reg.ts_value;
    assign ts_echo        = result_reg.ts_echo;

endmodule

// File: design/tofe_walk.sv
// Option walk state machine and per-kind hold registers.
`timescale 1ns / 1ps
module tofe_walk #(
    parameter int unsigned MAX_OPT_BYTES = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           opt_byte,
    input  logic                 is_last,
    input  logic                 region_empty,
    output tofe_pkg::holds_t     holds_after
);

    localparam int unsigned CW = $clog2(MAX_OPT_BYTES + 1);

    logic [1:0]       phase_reg, phase_next;
    logic             stopped_reg, stopped_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       left_reg, left_next;
    logic [63:0]      shift_reg, shift_next;
    logic [CW-1:0]    count_reg, count_next;
    tofe_pkg::holds_t holds_reg, holds_next;

    logic [7:0]       need;
    logic             commit;

    assign need = tofe_pkg::opt_need_len(kind_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        stopped_next = stopped_reg;
        kind_next    = kind_reg;
        left_next    = left_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        holds_next   = holds_reg;
        commit       = 1'b0;

        if (!region_empty && (count_reg < CW'(MAX_OPT_BYTES)))
        begin
            count_next = count_reg + CW'(1);
            if (!stopped_reg)
            begin
                unique case (phase_reg)
                    tofe_pkg::PH_LEN:
                    begin
                        if ((opt_byte < tofe_pkg::LEN_MIN) ||
                            ((need != 8'd0) && (opt_byte != need)))
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            left_next  = opt_byte - tofe_pkg::LEN_MIN;
                            shift_next = '0;
                            if (opt_byte == tofe_pkg::LEN_MIN)
                                commit = 1'b1;
                            else
                                phase_next = tofe_pkg::PH_BODY;
                        end
                    end
                    tofe_pkg::PH_BODY:
                    begin
                        shift_next = {shift_reg[55:0], opt_byte};
                        left_next  = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                            commit = 1'b1;
                    end
                    default:
                    begin
                        // end-of-list and no-op are single bytes
                        if ((opt_byte != tofe_pkg::KIND_EOL) &&
                            (opt_byte != tofe_pkg::KIND_NOP))
                        begin
                            kind_next  = opt_byte;
                            phase_next = tofe_pkg::PH_LEN;
                        end
                    end
                endcase
            end
        end

        if (commit)
        begin
            phase_next = tofe_pkg::PH_KIND;
            unique case (kind_reg)
                tofe_pkg::KIND_MSS:
                begin
                    holds_next.mss_valid = 1'b1;
                    holds_next.mss_value = shift_next[15:0];
                end
                tofe_pkg::KIND_WS:
                begin
                    holds_next.ws_valid = 1'b1;
                    holds_next.ws_shift = shift_next[7:0];
                end
                tofe_pkg::KIND_SACKP:
                    holds_next.sack = 1'b1;
                tofe_pkg::KIND_TS:
                begin
                    holds_next.ts_valid = 1'b1;
                    holds_next.ts_word  = shift_next;
                end
                default:
                    holds_next = holds_next;
            endcase
        end

        holds_after = region_empty ? '0 : holds_next;

        // region ends: back to the reset state
        if (region_empty || is_last)
        begin
            phase_next   = tofe_pkg::PH_KIND;
            stopped_next = 1'b0;
            kind_next    = '0;
            left_next    = '0;
            shift_next   = '0;
            count_next   = '0;
            holds_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tofe_pkg::PH_KIND;
            stopped_reg <= 1'b0;
            kind_reg    <= '0;
            left_reg    <= '0;
            shift_reg   <= '0;
            count_reg   <= '0;
            holds_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            stopped_reg <= stopped_next;
            kind_reg    <= kind_next;
            left_reg    <= left_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
            holds_reg   <= holds_next;
        end
    end

endmodule

// File: design/tofe_emit.sv
// Formats the hold registers into one result, including the scale decode.
`timescale 1ns / 1ps
module tofe_emit (
    input  tofe_pkg::holds_t  holds,
    output tofe_pkg::result_t result
);

    logic [tofe_pkg::FACTOR_W-1:0] factor;

    always_comb
    begin
        factor = '0;
        if (holds.ws_valid)
        begin
            // shifts past the top bit saturate
            if (holds.ws_shift > 8'(tofe_pkg::WS_MAX_SHIFT))
                factor[tofe_pkg::WS_MAX_SHIFT] = 1'b1;
            else
                factor[holds.ws_shift[5:0]] = 1'b1;
        end
    end

    always_comb
    begin
        result.mss_valid      = holds.mss_valid;
        result.mss_value      = holds.mss_valid ? holds.mss_value : 16'd0;
        result.wscale_valid   = holds.ws_valid;
        result.wscale_factor  = factor;
        result.sack_permitted = holds.sack;
        result.ts_valid       = holds.ts_valid;
        result.ts_value       = holds.ts_valid ? holds.ts_word[63:32] : 32'd0;
        result.ts_echo        = holds.ts_valid ? holds.ts_word[31:0] : 32'd0;
    end

endmodule

// File: design/tofe_checker.sv
// Port-level checks for the TCP option field extractor, bound to the top level.
`timescale 1ns / 1ps
module tofe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        opt_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic        mss_valid,
    input logic [15:0] mss_value,
    input logic        wscale_valid,
    input logic [62:0] wscale_factor,
    input logic        ts_valid,
    input logic [31:0] ts_value,
    input logic [31:0] ts_echo
);

    // an empty result register never holds back the input
    a_no_stall_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !opt_stall)
        else $error("opt_stall high while result register empty");

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("stalled result dropped");

    a_mss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !mss_valid |-> mss_value == 16'd0)
        else $error("mss_value non-zero without mss_valid");

    a_wscale_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (wscale_valid ? $onehot(wscale_factor) : (wscale_factor == '0)))
        else $error("wscale_factor not a single power of two");

    a_ts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !ts_valid |-> (ts_value == 32'd0) && (ts_echo == 32'd0))
        else $error("timestamp fields non-zero without ts_valid");

endmodule

bind tcp_option_field_extractor_unit tofe_checker u_tofe_checker (.*);
